// ----- sv/rmc_pkg.sv -----
package rmc_pkg;

    localparam int REGIONS_DEF    = 1024;
    localparam int COUNT_BITS_DEF = 23;

    localparam int SUM_W    = 30;
    localparam int CMD_W    = 2;
    localparam int REGION_W = 10;
    localparam int CHAN_W   = 8;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    // region + three channels, packed from bit 0
    localparam int IN_BITS  = REGION_W + 3 * CHAN_W;
    localparam int S_DATA_W = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS = REGION_W + 3 * CHAN_W;
    localparam int M_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_ACC = 2'd0,
        CMD_QRY = 2'd1,
        CMD_CLR = 2'd2,
        CMD_NOP = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_DIV,
        ST_OUT
    } state_t;

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] sum,
                                                 input logic [CHAN_W-1:0] px);
        logic [SUM_W:0] t;
        t = {1'b0, sum} + (SUM_W + 1)'(px);
        return t[SUM_W] ? SUM_MAX : t[SUM_W-1:0];
    endfunction

endpackage

// ----- sv/region_mean_color_unit.sv -----
// Per-region mean colour accumulator. A single-port-write, registered-read
// table of REGIONS entries holds three 30-bit channel sums and a COUNT_BITS
// pixel count per region. Every request takes one table read followed by a
// write-back or a decision, so an accumulate or clear request occupies the
// block for an accept step and then a read-modify-write; s_tready is high only
// between requests. A query runs the sums through a shared restoring divider
// producing one mean bit per cycle for all three channels: accept and read,
// eight divide steps, then the divider is seen to finish and the output
// register is loaded, before the next request is taken (an empty or
// out-of-table region skips the divide steps). The query also holds the block
// while its result waits for m_tready with the output register still full.
// A finished result sits in an output register, so following accumulates
// carry on while it waits.
// After reset the table is cleared one entry per cycle: s_tready stays low
// until all are zero. Sums saturate at 2^30-1, counts at 2^COUNT_BITS-1, and
// a mean above 255 is reported as 255. A query on an empty region or a region
// at or above REGIONS returns zero means with region_empty set; accumulate and
// clear requests outside the table, and command 3, are dropped silently.
module region_mean_color_unit #(
    parameter int REGIONS    = rmc_pkg::REGIONS_DEF,
    parameter int COUNT_BITS = rmc_pkg::COUNT_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // request channel
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // s_tdata: region[9:0], red[17:10], green[25:18], blue[33:26], zero pad
    input  logic [rmc_pkg::S_DATA_W-1:0] s_tdata,
    // s_tuser: cmd[1:0]
    input  logic [rmc_pkg::CMD_W-1:0]    s_tuser,
    // result channel
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // m_tdata: region_out[9:0], mean_red[17:10], mean_green[25:18],
    //          mean_blue[33:26], zero pad
    output logic [rmc_pkg::M_DATA_W-1:0] m_tdata,
    // m_tuser: region_empty[0]
    output logic [0:0]                   m_tuser
);

    localparam int AW = $clog2(REGIONS);
    localparam int SW = rmc_pkg::SUM_W;
    localparam int CW = rmc_pkg::CHAN_W;
    localparam int RW = rmc_pkg::REGION_W;
    localparam int EW = 3 * SW + COUNT_BITS;
    localparam int M_PAD = rmc_pkg::M_DATA_W - rmc_pkg::OUT_BITS;

    // request fields
    logic [RW-1:0] s_region;
    logic [CW-1:0] s_red, s_green, s_blue;
    logic          s_inside;
    logic          s_accept;

    assign s_region = s_tdata[RW-1:0];
    assign s_red    = s_tdata[RW+CW-1:RW];
    assign s_green  = s_tdata[RW+2*CW-1:RW+CW];
    assign s_blue   = s_tdata[RW+3*CW-1:RW+2*CW];
    assign s_inside = 32'(s_region) < 32'(REGIONS);
    assign s_accept = s_tvalid && s_tready;

    rmc_pkg::state_t state_reg, state_next;

    // held request (payload, no reset)
    rmc_pkg::cmd_t cmd_reg;
    logic [RW-1:0] region_reg;
    logic [CW-1:0] red_reg, green_reg, blue_reg;
    logic          inside_reg;
    logic          empty_reg;

    logic [AW-1:0] clr_addr_reg;

    // table ports
    logic          tbl_rd_en;
    logic [AW-1:0] tbl_rd_addr;
    logic [EW-1:0] tbl_rd_data;
    logic          tbl_wr_en;
    logic [AW-1:0] tbl_wr_addr;
    logic [EW-1:0] tbl_wr_data;

    // entry as read
    logic [SW-1:0]         ent_red, ent_green, ent_blue;
    logic [COUNT_BITS-1:0] ent_count;
    logic [EW-1:0]         ent_acc;

    // divider
    logic                     div_start;
    logic                     div_done;
    logic [2:0][CW-1:0]       div_means;

    // output register
    logic                         m_tvalid_reg;
    logic [rmc_pkg::M_DATA_W-1:0] m_tdata_reg;
    logic [0:0]                   m_tuser_reg;
    logic                         out_load;

    rmc_table #(
        .DEPTH (REGIONS),
        .AW    (AW),
        .WIDTH (EW)
    ) u_table (
        .aclk    (aclk),
        .rd_en   (tbl_rd_en),
        .rd_addr (tbl_rd_addr),
        .rd_data (tbl_rd_data),
        .wr_en   (tbl_wr_en),
        .wr_addr (tbl_wr_addr),
        .wr_data (tbl_wr_data)
    );

    rmc_div #(
        .COUNT_BITS (COUNT_BITS)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .sums    ({ent_blue, ent_green, ent_red}),
        .count   (ent_count),
        .done    (div_done),
        .means   (div_means)
    );

    assign ent_red   = tbl_rd_data[SW-1:0];
    assign ent_green = tbl_rd_data[2*SW-1:SW];
    assign ent_blue  = tbl_rd_data[3*SW-1:2*SW];
    assign ent_count = tbl_rd_data[EW-1:3*SW];

    // accumulate: saturating sums, sticky count at full scale
    assign ent_acc = {(&ent_count) ? ent_count : ent_count + 1'b1,
                      rmc_pkg::sat_add(ent_blue, blue_reg),
                      rmc_pkg::sat_add(ent_green, green_reg),
                      rmc_pkg::sat_add(ent_red, red_reg)};

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            rmc_pkg::ST_CLEAR: begin
                if (clr_addr_reg == AW'(REGIONS - 1)) begin
                    state_next = rmc_pkg::ST_IDLE;
                end
            end
            rmc_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = rmc_pkg::ST_EXEC;
                end
            end
            rmc_pkg::ST_EXEC: begin
                if (cmd_reg == rmc_pkg::CMD_QRY) begin
                    if (!inside_reg || ent_count == '0) begin
                        state_next = rmc_pkg::ST_OUT;
                    end else begin
                        state_next = rmc_pkg::ST_DIV;
                    end
                end else begin
                    state_next = rmc_pkg::ST_IDLE;
                end
            end
            rmc_pkg::ST_DIV: begin
                if (div_done) begin
                    state_next = rmc_pkg::ST_OUT;
                end
            end
            rmc_pkg::ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    state_next = rmc_pkg::ST_IDLE;
                end
            end
            default: state_next = rmc_pkg::ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        s_tready    = 1'b0;
        tbl_rd_en   = 1'b0;
        tbl_rd_addr = AW'(s_region);
        tbl_wr_en   = 1'b0;
        tbl_wr_addr = AW'(region_reg);
        tbl_wr_data = '0;
        div_start   = 1'b0;
        out_load    = 1'b0;
        case (state_reg)
            rmc_pkg::ST_CLEAR: begin
                tbl_wr_en   = 1'b1;
                tbl_wr_addr = clr_addr_reg;
            end
            rmc_pkg::ST_IDLE: begin
                s_tready  = 1'b1;
                tbl_rd_en = s_tvalid && s_inside;
            end
            rmc_pkg::ST_EXEC: begin
                case (cmd_reg)
                    rmc_pkg::CMD_ACC: begin
                        tbl_wr_en   = inside_reg;
                        tbl_wr_data = ent_acc;
                    end
                    rmc_pkg::CMD_CLR: begin
                        tbl_wr_en = inside_reg;
                    end
                    rmc_pkg::CMD_QRY: begin
                        div_start = inside_reg && ent_count != '0;
                    end
                    default: ;
                endcase
            end
            rmc_pkg::ST_DIV: ;
            rmc_pkg::ST_OUT: begin
                out_load = !m_tvalid_reg || m_tready;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= rmc_pkg::ST_CLEAR;
            clr_addr_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == rmc_pkg::ST_CLEAR) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // request and result payload
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            cmd_reg    <= rmc_pkg::cmd_t'(s_tuser);
            region_reg <= s_region;
            red_reg    <= s_red;
            green_reg  <= s_green;
            blue_reg   <= s_blue;
            inside_reg <= s_inside;
        end
        if (state_reg == rmc_pkg::ST_EXEC) begin
            empty_reg <= !inside_reg || ent_count == '0;
        end
        if (out_load) begin
            m_tuser_reg <= empty_reg;
            m_tdata_reg <= {{M_PAD{1'b0}},
                            empty_reg ? CW'(0) : div_means[2],
                            empty_reg ? CW'(0) : div_means[1],
                            empty_reg ? CW'(0) : div_means[0],
                            region_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ----- sv/rmc_table.sv -----
module rmc_table #(
    parameter int DEPTH = rmc_pkg::REGIONS_DEF,
    parameter int AW    = $clog2(DEPTH),
    parameter int WIDTH = 3 * rmc_pkg::SUM_W + rmc_pkg::COUNT_BITS_DEF
) (
    input  logic             aclk,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- sv/rmc_div.sv -----
// Radix-2 divider for the three channels at once; quotient clamped to 8 bits.
module rmc_div #(
    parameter int COUNT_BITS = rmc_pkg::COUNT_BITS_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   start,
    input  logic [2:0][rmc_pkg::SUM_W-1:0]         sums,
    input  logic [COUNT_BITS-1:0]                  count,
    output logic                                   done,
    output logic [2:0][rmc_pkg::CHAN_W-1:0]        means
);

    localparam int DW = (rmc_pkg::SUM_W > COUNT_BITS + rmc_pkg::CHAN_W)
                        ? rmc_pkg::SUM_W : COUNT_BITS + rmc_pkg::CHAN_W;
    localparam int SW = $clog2(rmc_pkg::CHAN_W);

    logic [2:0][DW-1:0]             rem_reg;
    logic [2:0][rmc_pkg::CHAN_W-1:0] quo_reg;
    logic [2:0]                     ovf_reg;
    logic [DW-1:0]                  den_reg;
    logic [SW-1:0]                  step_reg;
    logic                           busy_reg;
    logic                           done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= SW'(rmc_pkg::CHAN_W - 1);
            end else if (busy_reg) begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath: one quotient bit per cycle, msb first
    always_ff @(posedge aclk) begin
        if (start) begin
            den_reg <= DW'(count) << (rmc_pkg::CHAN_W - 1);
            for (int c = 0; c < 3; c++) begin
                rem_reg[c] <= DW'(sums[c]);
                quo_reg[c] <= '0;
                ovf_reg[c] <= DW'(sums[c]) >= (DW'(count) << rmc_pkg::CHAN_W);
            end
        end else if (busy_reg) begin
            den_reg <= den_reg >> 1;
            for (int c = 0; c < 3; c++) begin
                if (rem_reg[c] >= den_reg) begin
                    rem_reg[c] <= rem_reg[c] - den_reg;
                    quo_reg[c] <= {quo_reg[c][rmc_pkg::CHAN_W-2:0], 1'b1};
                end else begin
                    quo_reg[c] <= {quo_reg[c][rmc_pkg::CHAN_W-2:0], 1'b0};
                end
            end
        end
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            means[c] = ovf_reg[c] ? {rmc_pkg::CHAN_W{1'b1}} : quo_reg[c];
        end
    end

    assign done = done_reg;

endmodule

// ----- sv/rmc_checker.sv -----
module rmc_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic [rmc_pkg::CMD_W-1:0]    s_tuser,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [rmc_pkg::M_DATA_W-1:0] m_tdata,
    input logic [0:0]                   m_tuser
);

    // a held result stays offered
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_m_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // empty region reports zero means
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |->
            m_tdata[rmc_pkg::OUT_BITS-1:rmc_pkg::REGION_W] == '0)
        else $error("empty region with non-zero mean");

    // only a query makes a result
    a_no_spurious: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !m_tvalid && s_tuser != rmc_pkg::CMD_QRY
            |=> !m_tvalid)
        else $error("result without a query");

    // table clear pass holds requests off after reset
    a_clear_pass: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(aresetn) |-> !s_tready && !m_tvalid)
        else $error("request taken during clear pass");

endmodule

bind region_mean_color_unit rmc_checker u_rmc_checker (.*);
